### hw/rtl/mic_pkg.sv
// shared types and constants for the mesh index compaction core
// depends on nothing; imported by mic_cell, the core and its checker
`default_nettype none

package mic_pkg;

    // three index kinds per corner, three corners per triangle
    localparam int NUM_LANES   = 3;
    localparam int NUM_CORNERS = 3;
    localparam int FIELD_W     = 24;
    localparam int RES_W       = 8;
    localparam int OUT_MAX     = 255;

    // lane order inside a token
    localparam int LANE_POS = 0;
    localparam int LANE_TEX = 1;
    localparam int LANE_NRM = 2;

    // corner codes carried by a token
    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    typedef struct packed {
        logic               face_present;
        logic               last_face;
        logic [FIELD_W-1:0] pos_index_a;
        logic [FIELD_W-1:0] tex_index_a;
        logic [FIELD_W-1:0] nrm_index_a;
        logic [FIELD_W-1:0] pos_index_b;
        logic [FIELD_W-1:0] tex_index_b;
        logic [FIELD_W-1:0] nrm_index_b;
        logic [FIELD_W-1:0] pos_index_c;
        logic [FIELD_W-1:0] tex_index_c;
        logic [FIELD_W-1:0] nrm_index_c;
    } face_t;

    typedef struct packed {
        logic [RES_W-1:0] new_pos_a;
        logic [RES_W-1:0] new_tex_a;
        logic [RES_W-1:0] new_nrm_a;
        logic [RES_W-1:0] new_pos_b;
        logic [RES_W-1:0] new_tex_b;
        logic [RES_W-1:0] new_nrm_b;
        logic [RES_W-1:0] new_pos_c;
        logic [RES_W-1:0] new_tex_c;
        logic [RES_W-1:0] new_nrm_c;
        logic             table_overflow;
        logic             last_out;
    } result_t;

    // control part of a lookup token travelling along the cell chain
    typedef struct packed {
        logic                 valid;
        logic [1:0]           corner;
        logic [NUM_LANES-1:0] done;   // lane resolved by a hit or an append
        logic [NUM_LANES-1:0] added;  // lane appended a new entry
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/mic_cell.sv
// one cell of the renumbering chain: holds one entry of each table
// depends on mic_pkg; instantiated in a row by mesh_index_compaction_core
`default_nettype none

module mic_cell #(
    parameter int KEY_W    = 24,
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 9,
    parameter int CELL_IDX = 0
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic [mic_pkg::NUM_LANES-1:0][CNT_W-1:0]  count,
    input  wire mic_pkg::cell_ctl_t                        ctl_in,
    input  wire logic [mic_pkg::NUM_LANES-1:0][KEY_W-1:0]  key_in,
    input  wire logic [mic_pkg::NUM_LANES-1:0][IDX_W-1:0]  idx_in,
    output mic_pkg::cell_ctl_t                             ctl_out,
    output logic [mic_pkg::NUM_LANES-1:0][KEY_W-1:0]       key_out,
    output logic [mic_pkg::NUM_LANES-1:0][IDX_W-1:0]       idx_out
);
    import mic_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [NUM_LANES-1:0][KEY_W-1:0] entry_reg;
    // appended here by one of the two tokens just ahead
    logic [NUM_LANES-1:0]            app1_reg;
    logic [NUM_LANES-1:0]            app2_reg;
    logic [NUM_LANES-1:0]            used;
    logic [NUM_LANES-1:0]            hit;
    logic [NUM_LANES-1:0]            add;
    cell_ctl_t                       ctl_next;
    logic [NUM_LANES-1:0][IDX_W-1:0] idx_next;
    cell_ctl_t                       ctl_reg;
    logic [NUM_LANES-1:0][KEY_W-1:0] key_reg;
    logic [NUM_LANES-1:0][IDX_W-1:0] idx_reg;

    always_comb
    begin
        ctl_next = ctl_in;
        idx_next = idx_in;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            used[l] = (MY_POS < count[l]) | app1_reg[l] | app2_reg[l];
            hit[l]  = ctl_in.valid & ~ctl_in.done[l] & used[l] &
                      (entry_reg[l] == key_in[l]);
            add[l]  = ctl_in.valid & ~ctl_in.done[l] & ~used[l];
            if (hit[l] | add[l])
            begin
                ctl_next.done[l] = 1'b1;
                idx_next[l]      = MY_IDX;
            end
            if (add[l])
            begin
                ctl_next.added[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            app1_reg <= '0;
            app2_reg <= '0;
        end
        else
        begin
            ctl_reg  <= ctl_next;
            app1_reg <= add;
            app2_reg <= app1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_in;
        idx_reg <= idx_next;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (add[l])
            begin
                entry_reg[l] <= key_in[l];
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign key_out = key_reg;
    assign idx_out = idx_reg;

endmodule

`default_nettype wire

### hw/rtl/mesh_index_compaction_core.sv
// top level of the mesh index compaction core: sequencer, cell chain, result collector
// depends on mic_pkg and mic_cell
//
//  channel   direction  handshake                        payload
//  face      in         start high and busy low at edge  mic_pkg::face_t
//  result    out        done high for one cycle          mic_pkg::result_t
//
// a present triangle raises the done strobe, and busy drops in the cycle after it,
// so the next face can then be taken; the wait is set by the chain length, as each
// corner token walks one cell per cycle and the result waits for the third token
// to leave the last cell
// an absent triangle is taken without raising busy and gives no result
// reset clears sequencer, counts and token valids; table contents stay undefined
// the receiver cannot stall: one-cycle strobe, result held until the next face
`default_nettype none

module mesh_index_compaction_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int INDEX_BITS  = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire mic_pkg::face_t   face,
    output logic                  done,
    output mic_pkg::result_t      result
);
    import mic_pkg::*;

    // stored key width: only the low INDEX_BITS of a field count
    localparam int KEY_W = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    // working width for the saturation compare against the 8 bit result
    localparam int RW    = (IDX_W > RES_W) ? IDX_W : RES_W;

    state_t                          state_reg;
    state_t                          state_next;
    logic [1:0]                      corner_reg;
    logic [1:0]                      corner_next;
    face_t                           face_reg;
    logic [NUM_LANES-1:0][CNT_W-1:0] count_reg;
    logic [NUM_LANES-1:0][CNT_W-1:0] count_next;
    logic [NUM_LANES-1:0][RES_W-1:0] res_a_reg;
    logic [NUM_LANES-1:0][RES_W-1:0] res_b_reg;
    logic [NUM_LANES-1:0][RES_W-1:0] res_c_reg;
    logic                            ovf_reg;
    logic                            ovf_next;

    logic                            accept;
    logic                            issue;

    // head token built by the sequencer
    cell_ctl_t                       head_ctl;
    logic [NUM_LANES-1:0][KEY_W-1:0] head_key;

    // token chain: entry 0 is driven by the sequencer, the last entry leaves the row
    cell_ctl_t                       ctl_chain [TABLE_DEPTH+1];
    logic [NUM_LANES-1:0][KEY_W-1:0] key_chain [TABLE_DEPTH+1];
    logic [NUM_LANES-1:0][IDX_W-1:0] idx_chain [TABLE_DEPTH+1];

    cell_ctl_t                       exit_ctl;
    logic [NUM_LANES-1:0][RES_W-1:0] exit_res;
    logic [NUM_LANES-1:0]            exit_ovf;
    logic [IDX_W-1:0]                raw_idx;
    logic [RW-1:0]                   wide_idx;

    assign accept = start & ~busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && face.face_present)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (corner_reg == CORNER_C)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (exit_ctl.valid && exit_ctl.corner == CORNER_C)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy  = 1'b1;
        issue = 1'b0;
        done  = 1'b0;
        case (state_reg)
            ST_IDLE:  busy  = 1'b0;
            ST_ISSUE: issue = 1'b1;
            ST_WAIT:  busy  = 1'b1;
            ST_DONE:  done  = 1'b1;
            default:  busy  = 1'b1;
        endcase
    end

    // corner counter for issuing one token per cycle
    always_comb
    begin
        corner_next = corner_reg;
        if (accept)
        begin
            corner_next = CORNER_A;
        end
        else if (issue)
        begin
            corner_next = corner_reg + 2'd1;
        end
    end

    // head token: the current corner's three keys, nothing resolved yet
    always_comb
    begin
        head_ctl        = '0;
        head_ctl.valid  = issue;
        head_ctl.corner = corner_reg;
        case (corner_reg)
            CORNER_A:
            begin
                head_key[LANE_POS] = face_reg.pos_index_a[KEY_W-1:0];
                head_key[LANE_TEX] = face_reg.tex_index_a[KEY_W-1:0];
                head_key[LANE_NRM] = face_reg.nrm_index_a[KEY_W-1:0];
            end
            CORNER_B:
            begin
                head_key[LANE_POS] = face_reg.pos_index_b[KEY_W-1:0];
                head_key[LANE_TEX] = face_reg.tex_index_b[KEY_W-1:0];
                head_key[LANE_NRM] = face_reg.nrm_index_b[KEY_W-1:0];
            end
            default:
            begin
                head_key[LANE_POS] = face_reg.pos_index_c[KEY_W-1:0];
                head_key[LANE_TEX] = face_reg.tex_index_c[KEY_W-1:0];
                head_key[LANE_NRM] = face_reg.nrm_index_c[KEY_W-1:0];
            end
        endcase
    end

    assign ctl_chain[0] = head_ctl;
    assign key_chain[0] = head_key;
    assign idx_chain[0] = '0;

    // the row of cells, one entry of each table per cell
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        mic_cell #(
            .KEY_W    (KEY_W),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .count   (count_reg),
            .ctl_in  (ctl_chain[g]),
            .key_in  (key_chain[g]),
            .idx_in  (idx_chain[g]),
            .ctl_out (ctl_chain[g+1]),
            .key_out (key_chain[g+1]),
            .idx_out (idx_chain[g+1])
        );
    end

    assign exit_ctl = ctl_chain[TABLE_DEPTH];

    // leaving token: unresolved lane means a full table, saturate and flag;
    // an index above the 8 bit range saturates too
    always_comb
    begin
        raw_idx  = '0;
        wide_idx = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            raw_idx     = exit_ctl.done[l] ? idx_chain[TABLE_DEPTH][l]
                                           : IDX_W'(TABLE_DEPTH - 1);
            wide_idx    = RW'(raw_idx);
            exit_ovf[l] = ~exit_ctl.done[l];
            if (wide_idx > RW'(OUT_MAX))
            begin
                wide_idx    = RW'(OUT_MAX);
                exit_ovf[l] = 1'b1;
            end
            exit_res[l] = wide_idx[RES_W-1:0];
        end
    end

    // table fill counts: grow as tokens leave, clear after the last face
    always_comb
    begin
        count_next = count_reg;
        if (accept && !face.face_present && face.last_face)
        begin
            count_next = '0;
        end
        else if (done && face_reg.last_face)
        begin
            count_next = '0;
        end
        else if (exit_ctl.valid)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                count_next[l] = count_reg[l] + CNT_W'(exit_ctl.added[l]);
            end
        end
    end

    always_comb
    begin
        ovf_next = ovf_reg;
        if (accept)
        begin
            ovf_next = 1'b0;
        end
        else if (exit_ctl.valid)
        begin
            ovf_next = ovf_reg | (|exit_ovf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= CORNER_A;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

    // payload registers: accepted face and per-corner results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            face_reg <= face;
        end
        if (exit_ctl.valid)
        begin
            case (exit_ctl.corner)
                CORNER_A: res_a_reg <= exit_res;
                CORNER_B: res_b_reg <= exit_res;
                CORNER_C: res_c_reg <= exit_res;
                default:  res_c_reg <= exit_res;
            endcase
        end
    end

    always_comb
    begin
        result.new_pos_a      = res_a_reg[LANE_POS];
        result.new_tex_a      = res_a_reg[LANE_TEX];
        result.new_nrm_a      = res_a_reg[LANE_NRM];
        result.new_pos_b      = res_b_reg[LANE_POS];
        result.new_tex_b      = res_b_reg[LANE_TEX];
        result.new_nrm_b      = res_b_reg[LANE_NRM];
        result.new_pos_c      = res_c_reg[LANE_POS];
        result.new_tex_c      = res_c_reg[LANE_TEX];
        result.new_nrm_c      = res_c_reg[LANE_NRM];
        result.table_overflow = ovf_reg;
        result.last_out       = face_reg.last_face;
    end

endmodule

`default_nettype wire

### hw/rtl/mic_core_checker.sv
// port-level checks for the mesh index compaction core, bound to the top level
// depends on mic_pkg and mesh_index_compaction_core
`default_nettype none

module mic_core_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire mic_pkg::face_t   face,
    input wire logic             done,
    input wire mic_pkg::result_t result
);
    import mic_pkg::*;

    // a result only comes out of a transaction in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done strobe while not busy");

    // the block is free again right after a result
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block still busy after result");

    // a present face keeps the block busy
    a_present_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && face.face_present |=> busy && !done)
        else $error("present face not taken up");

    // an absent face is dropped without a result
    a_absent_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !face.face_present |=> !busy && !done)
        else $error("absent face produced work");

    // the overflow flag and the last copy only mean something with a strobe
    a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && face.face_present |=> ##1 $stable(result.last_out))
        else $error("last flag changed while face in flight");

endmodule

bind mesh_index_compaction_core mic_core_checker u_mic_core_checker (.*);

`default_nettype wire

### bench/mesh_index_compaction_core_tb.sv
`timescale 1ns / 100ps
// self-checking bench for mesh_index_compaction_core: directed and random triangle streams
// depends on mic_pkg and the core rtl; a clocked driver, a clocked monitor and an in-bench remapper
module mesh_index_compaction_core_tb;

    import mic_pkg::*;

    // core build under test, kept equal to the defaults of the block
    localparam int TABLE_DEPTH = 256;
    localparam int INDEX_BITS  = 24;

    // only the low INDEX_BITS of an original index take part in the lookup
    localparam logic [FIELD_W-1:0] IDX_MASK = {FIELD_W{1'b1}} >> (FIELD_W - INDEX_BITS);
    localparam logic [FIELD_W-1:0] IDX_ONES = {FIELD_W{1'b1}};

    // total faces queued, directed ones included
    localparam int RANDOM_FACES  = 1050;
    localparam int POOL_MAX      = 16;
    localparam int SEEN_MAX      = 512;
    localparam int REPORT_LIMIT  = 10;
    // done strobe comes once the third corner token leaves the chain, busy drops after it
    localparam int DRAIN_CYCLES  = TABLE_DEPTH + 16;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    face_t   face_in = '0;
    logic    busy;
    logic    done;
    result_t result;

    // faces waiting for the driver, and compacted results owed by the core
    face_t   faces_to_send [$];
    result_t compacted_due [$];

    // bench copy of the three first-seen renumbering tables
    logic [FIELD_W-1:0] remap_entry [NUM_LANES][TABLE_DEPTH];
    int unsigned        remap_count [NUM_LANES];
    logic               overflow_hit;

    // stimulus pools for the random sub-meshes
    logic [FIELD_W-1:0] pool_vals [NUM_LANES][POOL_MAX];
    int                 pool_n;
    logic [FIELD_W-1:0] seen_vals [NUM_LANES][SEEN_MAX];
    int                 seen_n [NUM_LANES];

    int total_faces      = 0;
    int present_queued   = 0;
    int faces_taken      = 0;
    int results_checked  = 0;
    int overflow_results = 0;
    int meshes_closed    = 0;
    int mismatches       = 0;
    int unexpected       = 0;

    mesh_index_compaction_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_BITS  (INDEX_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .face   (face_in),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // remapper: mirrors the table behaviour of the core
    // ------------------------------------------------------------------

    // look one index up in its lane's table, appending it when unseen
    function automatic logic [RES_W-1:0] renumber(input int lane, input logic [FIELD_W-1:0] raw);
        logic [FIELD_W-1:0] idx;
        int unsigned        slot;
        bit                 found;
        idx   = raw & IDX_MASK;
        found = 1'b0;
        slot  = 0;
        for (int unsigned i = 0; i < remap_count[lane] && i < TABLE_DEPTH; i++)
        begin
            if (!found && remap_entry[lane][i] == idx)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (!found)
        begin
            if (remap_count[lane] < TABLE_DEPTH)
            begin
                // unseen index takes the next dense number
                slot = remap_count[lane];
                remap_entry[lane][slot] = idx;
                remap_count[lane]++;
            end
            else
            begin
                // full table: saturate, nothing stored
                slot = TABLE_DEPTH - 1;
                overflow_hit = 1'b1;
            end
        end
        if (slot > OUT_MAX)
        begin
            slot = OUT_MAX;
            overflow_hit = 1'b1;
        end
        return slot[RES_W-1:0];
    endfunction

    // work out what one accepted face owes; corners go a, b, c in turn
    function automatic void renumber_face(input face_t f);
        result_t r;
        if (f.face_present)
        begin
            overflow_hit = 1'b0;
            r.new_pos_a = renumber(LANE_POS, f.pos_index_a);
            r.new_tex_a = renumber(LANE_TEX, f.tex_index_a);
            r.new_nrm_a = renumber(LANE_NRM, f.nrm_index_a);
            r.new_pos_b = renumber(LANE_POS, f.pos_index_b);
            r.new_tex_b = renumber(LANE_TEX, f.tex_index_b);
            r.new_nrm_b = renumber(LANE_NRM, f.nrm_index_b);
            r.new_pos_c = renumber(LANE_POS, f.pos_index_c);
            r.new_tex_c = renumber(LANE_TEX, f.tex_index_c);
            r.new_nrm_c = renumber(LANE_NRM, f.nrm_index_c);
            r.table_overflow = overflow_hit;
            r.last_out       = f.last_face;
            compacted_due.push_back(r);
        end
        // an absent face marked last still clears every table
        if (f.last_face)
        begin
            for (int lane = 0; lane < NUM_LANES; lane++)
                remap_count[lane] = 0;
            meshes_closed++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_face(input bit present, input bit last,
                              input logic [FIELD_W-1:0] pa, input logic [FIELD_W-1:0] ta,
                              input logic [FIELD_W-1:0] na, input logic [FIELD_W-1:0] pb,
                              input logic [FIELD_W-1:0] tb, input logic [FIELD_W-1:0] nb,
                              input logic [FIELD_W-1:0] pc, input logic [FIELD_W-1:0] tc,
                              input logic [FIELD_W-1:0] nc);
        face_t f;
        f.face_present = present;
        f.last_face    = last;
        f.pos_index_a  = pa;
        f.tex_index_a  = ta;
        f.nrm_index_a  = na;
        f.pos_index_b  = pb;
        f.tex_index_b  = tb;
        f.nrm_index_b  = nb;
        f.pos_index_c  = pc;
        f.tex_index_c  = tc;
        f.nrm_index_c  = nc;
        faces_to_send.push_back(f);
        if (present)
            present_queued++;
    endtask

    // full-range index with a bias towards the two extremes
    function automatic logic [FIELD_W-1:0] rand_field();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? IDX_ONES : '0;
        return FIELD_W'($urandom);
    endfunction

    // long meshes mostly bring fresh indices so the tables fill and saturate,
    // short ones draw from a small pool so hits dominate
    function automatic logic [FIELD_W-1:0] pick_index(input int lane, input bit long_mesh);
        logic [FIELD_W-1:0] v;
        if (long_mesh)
        begin
            if (seen_n[lane] == 0 || $urandom_range(0, 99) < 85)
            begin
                v = rand_field();
                if (seen_n[lane] < SEEN_MAX)
                begin
                    seen_vals[lane][seen_n[lane]] = v;
                    seen_n[lane]++;
                end
            end
            else
                v = seen_vals[lane][$urandom_range(0, seen_n[lane] - 1)];
        end
        else if ($urandom_range(0, 99) < 85)
            v = pool_vals[lane][$urandom_range(0, pool_n - 1)];
        else
            v = rand_field();
        return v;
    endfunction

    // sender idle share per hundred cycles: light, then heavy, then none
    function automatic int idle_pct();
        if (faces_taken < total_faces / 3)
            return 34;
        if (faces_taken < (2 * total_faces) / 3)
            return 85;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // driver: one transaction per start/busy handshake
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            face_in <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                renumber_face(face_in);
                faces_taken++;
            end
            // offer a new face only when none is held waiting on busy
            if (!start || !busy)
            begin
                if (faces_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct())
                begin
                    face_in <= faces_to_send.pop_front();
                    start   <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each done strobe is one result transaction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (compacted_due.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= REPORT_LIMIT)
                    $display("[%0t] result with nothing outstanding: %h", $realtime, result);
            end
            else
            begin
                check_result(result);
            end
        end
    end

    function automatic void check_result(input result_t got);
        result_t want;
        bit      bad;
        want = compacted_due.pop_front();
        results_checked++;
        if (want.table_overflow)
            overflow_results++;
        bad = (got.new_pos_a !== want.new_pos_a) || (got.new_tex_a !== want.new_tex_a)
           || (got.new_nrm_a !== want.new_nrm_a) || (got.new_pos_b !== want.new_pos_b)
           || (got.new_tex_b !== want.new_tex_b) || (got.new_nrm_b !== want.new_nrm_b)
           || (got.new_pos_c !== want.new_pos_c) || (got.new_tex_c !== want.new_tex_c)
           || (got.new_nrm_c !== want.new_nrm_c)
           || (got.table_overflow !== want.table_overflow)
           || (got.last_out !== want.last_out);
        if (bad)
        begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_LIMIT)
            begin
                $display("[%0t] mismatch on result %0d", $realtime, results_checked);
                $display("  expected a %0d/%0d/%0d b %0d/%0d/%0d c %0d/%0d/%0d ovf %0b last %0b",
                         want.new_pos_a, want.new_tex_a, want.new_nrm_a,
                         want.new_pos_b, want.new_tex_b, want.new_nrm_b,
                         want.new_pos_c, want.new_tex_c, want.new_nrm_c,
                         want.table_overflow, want.last_out);
                $display("  actual   a %0d/%0d/%0d b %0d/%0d/%0d c %0d/%0d/%0d ovf %0b last %0b",
                         got.new_pos_a, got.new_tex_a, got.new_nrm_a,
                         got.new_pos_b, got.new_tex_b, got.new_nrm_b,
                         got.new_pos_c, got.new_tex_c, got.new_nrm_c,
                         got.table_overflow, got.last_out);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        bit long_mesh;
        bit present;
        bit last;
        int mesh_len;
        int leftover;

        for (int lane = 0; lane < NUM_LANES; lane++)
            remap_count[lane] = 0;

        // directed: extremes, hits, absent faces and clearing
        queue_face(1, 0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_face(1, 0, IDX_ONES, IDX_ONES, IDX_ONES, '0, '0, '0,
                   IDX_ONES, IDX_ONES, IDX_ONES);
        queue_face(1, 0, 24'hAAAAAA, 24'h555555, '0, 24'h555555, 24'hAAAAAA, IDX_ONES,
                   24'hAAAAAA, 24'h555555, '0);
        // absent face, contents ignored
        queue_face(0, 0, rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
                   rand_field(), rand_field(), rand_field(), rand_field());
        // absent face closing the sub-mesh still clears
        queue_face(0, 1, IDX_ONES, IDX_ONES, IDX_ONES, IDX_ONES, IDX_ONES, IDX_ONES,
                   IDX_ONES, IDX_ONES, IDX_ONES);
        queue_face(1, 0, IDX_ONES, IDX_ONES, IDX_ONES, IDX_ONES, IDX_ONES, IDX_ONES,
                   IDX_ONES, IDX_ONES, IDX_ONES);
        // present face marked last
        queue_face(1, 1, 24'd1, 24'd2, 24'd3, 24'd2, 24'd2, 24'd1, 24'd1, 24'd3, 24'd1);
        queue_face(1, 0, 24'h123456, 24'h123456, 24'h123456, 24'h123456, 24'h123456,
                   24'h123456, 24'h123456, 24'h123456, 24'h123456);
        queue_face(1, 0, '0, 24'd2, 24'd7, 24'd1, 24'd1, 24'd7, 24'd2, '0, 24'd8);
        queue_face(1, 0, 24'd2, 24'd1, 24'd8, 24'h123456, '0, 24'd9, 24'hFFFFFE, 24'd2, 24'd7);
        queue_face(1, 1, '0, '0, '0, '0, '0, '0, '0, '0, '0);

        // random sub-meshes until the face budget is queued
        while (faces_to_send.size() < RANDOM_FACES)
        begin
            long_mesh = ($urandom_range(0, 11) == 0);
            mesh_len  = long_mesh ? $urandom_range(110, 140) : $urandom_range(1, 24);
            if (mesh_len > RANDOM_FACES - faces_to_send.size())
                mesh_len = RANDOM_FACES - faces_to_send.size();
            pool_n    = $urandom_range(1, POOL_MAX);
            for (int lane = 0; lane < NUM_LANES; lane++)
            begin
                seen_n[lane] = 0;
                for (int j = 0; j < POOL_MAX; j++)
                    pool_vals[lane][j] = rand_field();
            end
            for (int k = 0; k < mesh_len; k++)
            begin
                present = ($urandom_range(0, 15) != 0);
                // now and then an absent face cuts the sub-mesh short
                last = (k == mesh_len - 1) || (!present && $urandom_range(0, 39) == 0);
                queue_face(present, last,
                           pick_index(LANE_POS, long_mesh), pick_index(LANE_TEX, long_mesh),
                           pick_index(LANE_NRM, long_mesh), pick_index(LANE_POS, long_mesh),
                           pick_index(LANE_TEX, long_mesh), pick_index(LANE_NRM, long_mesh),
                           pick_index(LANE_POS, long_mesh), pick_index(LANE_TEX, long_mesh),
                           pick_index(LANE_NRM, long_mesh));
            end
        end
        total_faces = faces_to_send.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // everything sent and every owed result seen, then a quiet drain
        @(posedge clk);
        while (faces_to_send.size() != 0 || start || compacted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        leftover = compacted_due.size();
        $display("faces sent %0d (%0d present) in %0d sub-meshes, results checked %0d, saturated %0d",
                 faces_taken, present_queued, meshes_closed, results_checked, overflow_results);
        $display("mismatches %0d, unexpected results %0d, results outstanding %0d",
                 mismatches, unexpected, leftover);
        if (mismatches == 0 && unexpected == 0 && leftover == 0)
            $display("** mesh_index_compaction_core: PASSED **");
        else
            $display("** mesh_index_compaction_core: FAILED **");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #30_000_000;
        $display("timeout with %0d results outstanding", compacted_due.size());
        $display("** mesh_index_compaction_core: FAILED **");
        $finish;
    end

endmodule
